@@ hdl/srm_pkg.sv @@
// Package for the stereo ring modulator: register indexes and the sine table generator.
package srm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_PHASE_INC = 3'd0;
    localparam logic [2:0] REG_WAVEFORM  = 3'd1;
    localparam logic [2:0] REG_DEPTH     = 3'd2;
    localparam logic [2:0] REG_SPREAD    = 3'd3;
    localparam logic [2:0] REG_MIX       = 3'd4;
    localparam logic [2:0] REG_MONO      = 3'd5;

    // Carrier shape codes.
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    // Reset values of the configuration registers and the spread limit.
    localparam logic [31:0] PHASE_INC_RESET = 32'd39370534;
    localparam logic [15:0] ONE_Q15         = 16'd32768;
    localparam logic [31:0] HALF_CYCLE      = 32'h8000_0000;

    // Pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // One quarter-wave sine entry in Q15: a Q30 Taylor series up to x^13,
    // each term truncated, then rounded to Q15 and clamped to one.
    function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        v = ($unsigned(sum) + 64'd16384) >> 15;
        if (v > 64'd32768)
        begin
            v = 64'd32768;
        end
        return v[15:0];
    endfunction

endpackage

@@ hdl/stereo_ring_modulator.sv @@
// Stereo ring modulator with depth and dry/wet mix, built around one shared multiplier.
//
//  Channel   Direction  Handshake          Payload
//  s_axis    in         s_tvalid/s_tready  s_tdata: left_in, right_in
//  m_axis    out        m_tvalid/m_tready  m_tdata: left_out, right_out
//  cfg       in         cfg_valid/ready    cfg_index, cfg_data
//
// An item is accepted in the idle state, then each channel (one in mono mode, two
// in stereo mode) runs eight steps through the shared multiplier (three products
// per channel) and the registered sine table read.
// Reset (rst_n low) clears the phase and m_tvalid and loads the configuration defaults.
// The input is ready only while the sequencer is idle; a finished beat waits in
// the output register, and the sequencer stalls on its last step while it is full.
module stereo_ring_modulator #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input beat, fields from bit 0: left_in, right_in.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // Output beat, fields from bit 0: left_out, right_out.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_index,
    input  logic [31:0]                            cfg_data
);

    localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int ROM_N   = 1 << SINE_TABLE_BITS;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = SAMPLE_BITS + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [PROD_W-1:0] OUT_HI = (PROD_W'(1) << (SAMPLE_BITS-1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] OUT_LO = -(PROD_W'(1) << (SAMPLE_BITS-1));
    localparam logic signed [PROD_W-1:0] OUT_RND = PROD_W'(1) << 29;

    localparam logic [31:0] HALF_CYCLE_C = srm_pkg::HALF_CYCLE;

    typedef logic [15:0] sine_rom_t [0:ROM_N];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= ROM_N; k++)
        begin
            rom[k] = srm_pkg::sine_entry(k, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ADDR = 9'b000000010,
        S_CAR  = 9'b000000100,
        S_MCD  = 9'b000001000,
        S_EXPR = 9'b000010000,
        S_MME  = 9'b000100000,
        S_GAIN = 9'b001000000,
        S_MDG  = 9'b010000000,
        S_SAT  = 9'b100000000
    } state_t;

    // Registers.
    state_t                          state_reg, state_next;
    logic                            ch_reg;
    logic [31:0]                     phase_reg;
    logic [31:0]                     ch_phase_reg;
    logic [31:0]                     phase_inc_reg;
    logic [1:0]                      waveform_reg;
    logic [15:0]                     depth_reg;
    logic [31:0]                     spread_reg;
    logic [15:0]                     mix_reg;
    logic                            mono_reg;
    logic signed [SAMPLE_BITS-1:0]   dry_l_reg;
    logic signed [SAMPLE_BITS-1:0]   dry_r_reg;
    logic [15:0]                     rom_data_reg;
    logic signed [16:0]              c_reg;
    logic signed [33:0]              e_reg;
    logic signed [31:0]              g30_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [SAMPLE_BITS-1:0]   left_res_reg;
    logic                            m_tvalid_reg;
    logic [TDATA_W-1:0]              m_tdata_reg;

    // Combinational signals.
    logic                            in_fire;
    logic                            out_free;
    logic                            last_chan;
    logic                            load_out;
    logic [SINE_TABLE_BITS:0]        rom_addr;
    logic [SINE_TABLE_BITS-1:0]      rom_idx;
    logic [31:0]                     tri_dist;
    logic signed [16:0]              c_next;
    logic signed [16:0]              sine_val;
    logic signed [34:0]              e_wide;
    logic signed [48:0]              g_wide;
    logic signed [48:0]              g_shift;
    logic signed [PROD_W-1:0]        y_rnd;
    logic signed [PROD_W-1:0]        y_shift;
    logic signed [SAMPLE_BITS-1:0]   y_sat;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_chan = ch_reg || mono_reg;
    assign load_out  = (state_reg == S_SAT) && last_chan && out_free;

    // Sine table address from the quadrant and the truncated index.
    assign rom_idx  = ch_phase_reg[29 -: SINE_TABLE_BITS];
    assign rom_addr = ch_phase_reg[30] ? ((SINE_TABLE_BITS+1)'(ROM_N) - {1'b0, rom_idx})
                                       : {1'b0, rom_idx};

    // Carrier value for the selected shape.
    always_comb
    begin
        tri_dist = ch_phase_reg[31] ? {1'b0, ch_phase_reg[30:0]} : (HALF_CYCLE_C - ch_phase_reg);
        sine_val = ch_phase_reg[31] ? -$signed({1'b0, rom_data_reg})
                                    : $signed({1'b0, rom_data_reg});
        case (waveform_reg)
            srm_pkg::WAVE_TRIANGLE:
            begin
                c_next = $signed(tri_dist[31:15]) - 17'sd32768;
            end
            srm_pkg::WAVE_SQUARE:
            begin
                c_next = ch_phase_reg[31] ? -17'sd32768 : 17'sd32768;
            end
            default:
            begin
                c_next = sine_val;
            end
        endcase
    end

    // Modulator minus one in Q31: 2^15*(c - D) + c*D - 2^30.
    assign e_wide = ((35'(c_reg) - 35'($signed({1'b0, depth_reg}))) <<< 15)
                    + 35'($signed(prod_reg[31:0])) - 35'sd1073741824;

    // Gain in Q46 is 2^46 + M*e; round to Q30.
    assign g_wide  = $signed(prod_reg[48:0]) + 49'sh4000_0000_8000;
    assign g_shift = g_wide >>> 16;

    // Output rounding and saturation.
    always_comb
    begin
        y_rnd   = prod_reg + OUT_RND;
        y_shift = y_rnd >>> 30;
        if (y_shift > OUT_HI)
        begin
            y_sat = OUT_HI[SAMPLE_BITS-1:0];
        end
        else if (y_shift < OUT_LO)
        begin
            y_sat = OUT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = y_shift[SAMPLE_BITS-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_MCD:
            begin
                mul_a = MUL_A_W'(c_reg);
                mul_b = MUL_B_W'($signed({1'b0, depth_reg}));
            end
            S_MME:
            begin
                mul_a = e_reg;
                mul_b = MUL_B_W'($signed({1'b0, mix_reg}));
            end
            default:
            begin
                mul_a = MUL_A_W'(g30_reg);
                mul_b = ch_reg ? MUL_B_W'(dry_r_reg) : MUL_B_W'(dry_l_reg);
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        case (state_reg)
            S_IDLE: state_next = in_fire ? S_ADDR : S_IDLE;
            S_ADDR: state_next = S_CAR;
            S_CAR:  state_next = S_MCD;
            S_MCD:  state_next = S_EXPR;
            S_EXPR: state_next = S_MME;
            S_MME:  state_next = S_GAIN;
            S_GAIN: state_next = S_MDG;
            S_MDG:  state_next = S_SAT;
            S_SAT:
            begin
                if (!last_chan)
                begin
                    state_next = S_ADDR;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SAT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, phase accumulator and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            phase_reg     <= '0;
            phase_inc_reg <= srm_pkg::PHASE_INC_RESET;
            waveform_reg  <= srm_pkg::WAVE_SINE;
            depth_reg     <= srm_pkg::ONE_Q15;
            spread_reg    <= '0;
            mix_reg       <= srm_pkg::ONE_Q15;
            mono_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                ch_reg    <= 1'b0;
                phase_reg <= phase_reg + phase_inc_reg;
            end
            else if ((state_reg == S_SAT) && !last_chan)
            begin
                ch_reg <= 1'b1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    srm_pkg::REG_PHASE_INC: phase_inc_reg <= cfg_data;
                    srm_pkg::REG_WAVEFORM:  waveform_reg  <= cfg_data[1:0];
                    srm_pkg::REG_DEPTH:
                    begin
                        depth_reg <= (cfg_data[15:0] > srm_pkg::ONE_Q15) ? srm_pkg::ONE_Q15
                                                                         : cfg_data[15:0];
                    end
                    srm_pkg::REG_SPREAD:
                    begin
                        spread_reg <= (cfg_data > HALF_CYCLE_C) ? HALF_CYCLE_C : cfg_data;
                    end
                    srm_pkg::REG_MIX:
                    begin
                        mix_reg <= (cfg_data[15:0] > srm_pkg::ONE_Q15) ? srm_pkg::ONE_Q15
                                                                       : cfg_data[15:0];
                    end
                    srm_pkg::REG_MONO:      mono_reg      <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_phase_reg <= phase_reg;
            dry_l_reg    <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            dry_r_reg    <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        else if ((state_reg == S_SAT) && !last_chan)
        begin
            ch_phase_reg <= ch_phase_reg + spread_reg;
        end
        if (state_reg == S_ADDR)
        begin
            rom_data_reg <= SINE_ROM[rom_addr];
        end
        if (state_reg == S_CAR)
        begin
            c_reg <= c_next;
        end
        if (state_reg == S_EXPR)
        begin
            e_reg <= e_wide[33:0];
        end
        if (state_reg == S_GAIN)
        begin
            g30_reg <= g_shift[31:0];
        end
        if ((state_reg == S_MCD) || (state_reg == S_MME) || (state_reg == S_MDG))
        begin
            prod_reg <= mul_a * mul_b;
        end
        if ((state_reg == S_SAT) && !last_chan)
        begin
            left_res_reg <= y_sat;
        end
        // Mono mode delivers the left result with a zero right field.
        if (load_out)
        begin
            if (mono_reg)
            begin
                m_tdata_reg <= TDATA_W'({{SAMPLE_BITS{1'b0}}, y_sat});
            end
            else
            begin
                m_tdata_reg <= TDATA_W'({y_sat, left_res_reg});
            end
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the stereo ring modulator: directed and random beats against a bit-true predictor.
module testbench;

    localparam int          TABLE_BITS    = 8;
    localparam int          TABLE_SIZE    = 1 << TABLE_BITS;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          RANDOM_PHASES = 12;
    localparam logic [1:0]  WAVE_ALIAS    = 2'd3;
    localparam longint      UNITY         = 32768;
    localparam longint      OUT_HI        = 8388607;
    localparam longint      OUT_LO        = -8388608;
    localparam logic [23:0] FULL_POS      = 24'h7F_FFFF;
    localparam logic [23:0] FULL_NEG      = 24'h80_0000;
    localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;

    // One stereo beat, left in the low half as on the bus.
    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } stereo_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Predicted configuration and carrier phase.
    logic [31:0] cur_step;
    logic [31:0] cur_spread;
    logic [31:0] carrier_phase;
    logic [1:0]  cur_wave;
    logic [15:0] cur_depth;
    logic [15:0] cur_mix;
    logic        cur_mono;
    int          quarter_sine [0:TABLE_SIZE];

    stereo_t     pending_samples [$];
    stereo_t     expected_out [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          in_wait;
    int          out_wait;
    bit          steady      = 1'b0;

    stereo_ring_modulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Carrier, modulator and dry/wet blend for one channel, rounded and saturated.
    function automatic logic [23:0] modulate_sample(input logic signed [23:0] dry,
                                                    input logic [31:0] p);
        logic [31:0] phase_gap;
        logic [7:0]  idx;
        longint      c;
        longint      carrier_mod;
        longint      gain46;
        longint      gain30;
        longint      acc;
        idx       = p[29:22];
        phase_gap = p[31] ? p - srm_pkg::HALF_CYCLE : srm_pkg::HALF_CYCLE - p;
        case (cur_wave)
            srm_pkg::WAVE_TRIANGLE: c = longint'(phase_gap >> 15) - UNITY;
            srm_pkg::WAVE_SQUARE:   c = p[31] ? -UNITY : UNITY;
            default:
            begin
                // Sine and the spare code both read the quarter-wave table.
                c = p[30] ? quarter_sine[TABLE_SIZE - idx] : quarter_sine[idx];
                if (p[31])
                begin
                    c = -c;
                end
            end
        endcase
        carrier_mod = (UNITY + c) * (UNITY - longint'(cur_depth))
                      + 2 * longint'(cur_depth) * c;
        gain46 = (UNITY - longint'(cur_mix)) * (longint'(1) <<< 31)
                 + longint'(cur_mix) * carrier_mod;
        gain30 = (gain46 + (longint'(1) <<< 15)) >>> 16;
        acc    = (longint'(dry) * gain30 + (longint'(1) <<< 29)) >>> 30;
        if (acc > OUT_HI)
        begin
            acc = OUT_HI;
        end
        else if (acc < OUT_LO)
        begin
            acc = OUT_LO;
        end
        return acc[23:0];
    endfunction

    // Register value: zero, the top of the range, all ones, slow values or anything.
    function automatic logic [31:0] pick_word(input logic [31:0] top);
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return top;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 32'h0400_0000);
            4:       return $urandom_range(0, top);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return 24'($urandom_range(0, 3)) - 24'd2;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_pair(input logic [23:0] l, input logic [23:0] r);
        pending_samples.push_back({r, l});
    endtask

    // Register write; the predicted copy follows once the beat is taken.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            srm_pkg::REG_PHASE_INC: cur_step   = val;
            srm_pkg::REG_WAVEFORM:  cur_wave   = val[1:0];
            srm_pkg::REG_DEPTH:
                cur_depth  = (val[15:0] > srm_pkg::ONE_Q15) ? srm_pkg::ONE_Q15 : val[15:0];
            srm_pkg::REG_SPREAD:
                cur_spread = (val > srm_pkg::HALF_CYCLE) ? srm_pkg::HALF_CYCLE : val;
            srm_pkg::REG_MIX:
                cur_mix    = (val[15:0] > srm_pkg::ONE_Q15) ? srm_pkg::ONE_Q15 : val[15:0];
            srm_pkg::REG_MONO:      cur_mono   = val[0];
            default:       ;
        endcase
    endtask

    // Hold off until every queued beat went in and every result came back.
    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid || expected_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input side: present queued beats with random gaps and predict each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : in_side
        stereo_t            beat;
        stereo_t            want;
        logic signed [23:0] right_dry;
        int                 gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            in_wait  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                beat       = stereo_t'(s_tdata);
                right_dry  = cur_mono ? beat.left : beat.right;
                want.left  = modulate_sample(beat.left, carrier_phase);
                want.right = cur_mono ? 24'd0
                                      : modulate_sample(right_dry, carrier_phase + cur_spread);
                expected_out.push_back(want);
                carrier_phase = carrier_phase + cur_step;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_wait > 0)
                begin
                    in_wait  <= in_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    gap      = steady ? 0 : $urandom_range(0, 8);
                    s_tdata  <= pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    in_wait  <= gap;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure after each beat, field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin : out_side
        stereo_t got;
        stereo_t want;
        int      stall;
        if (!rst_n)
        begin
            m_tready <= 1'b1;
            out_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = stereo_t'(m_tdata);
            if (expected_out.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("%0t: unexpected beat left %h right %h", $realtime,
                             got.left, got.right);
                end
            end
            else
            begin
                want = expected_out.pop_front();
                if (got.left !== want.left || got.right !== want.right)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: left exp %h got %h, right exp %h got %h", $realtime,
                                 want.left, got.left, want.right, got.right);
                    end
                end
            end
            stall    = steady ? 0 : $urandom_range(0, 8);
            out_wait <= stall;
            m_tready <= (stall == 0);
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            m_tready <= (out_wait == 1);
        end
    end

    // Watchdog on cycles without any beat on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          batch;
        cur_step      = srm_pkg::PHASE_INC_RESET;
        cur_wave      = srm_pkg::WAVE_SINE;
        cur_depth     = srm_pkg::ONE_Q15;
        cur_spread    = '0;
        cur_mix       = srm_pkg::ONE_Q15;
        cur_mono      = 1'b0;
        carrier_phase = '0;

        // Quarter-wave table from a truncated Q30 Taylor series, rounded to Q15.
        for (int k = 0; k <= TABLE_SIZE; k++)
        begin
            x    = (QUARTER_TURN * 64'(k)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 16384) / 32768;
            if (sum > UNITY)
            begin
                sum = UNITY;
            end
            quarter_sine[k] = int'(sum);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sample extremes on both channels.
        @(negedge clk);
        queue_pair(FULL_POS, FULL_NEG);
        queue_pair(FULL_NEG, FULL_POS);
        queue_pair(24'd0, 24'd0);
        queue_pair(FULL_POS, FULL_POS);
        queue_pair(FULL_NEG, FULL_NEG);
        queue_pair(24'hFF_FFFF, 24'd1);
        queue_pair(24'd1, 24'hFF_FFFF);
        queue_pair(pick_sample(), pick_sample());
        settle();

        // Triangle at half-cycle steps, pure tremolo, right carrier half a cycle ahead.
        write_reg(srm_pkg::REG_WAVEFORM, {30'd0, srm_pkg::WAVE_TRIANGLE});
        write_reg(srm_pkg::REG_PHASE_INC, srm_pkg::HALF_CYCLE);
        write_reg(srm_pkg::REG_DEPTH, 32'd0);
        write_reg(srm_pkg::REG_SPREAD, srm_pkg::HALF_CYCLE);
        @(negedge clk);
        queue_pair(FULL_POS, FULL_NEG);
        queue_pair(FULL_NEG, FULL_POS);
        queue_pair(FULL_POS, FULL_POS);
        queue_pair(FULL_NEG, FULL_NEG);
        settle();

        // Square with over-range depth and spread, step that wraps the phase.
        write_reg(srm_pkg::REG_WAVEFORM, {30'd0, srm_pkg::WAVE_SQUARE});
        write_reg(srm_pkg::REG_DEPTH, 32'h0000_FFFF);
        write_reg(srm_pkg::REG_SPREAD, 32'hFFFF_FFFF);
        write_reg(srm_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(srm_pkg::REG_MIX, 32'h0000_4000);
        @(negedge clk);
        queue_pair(FULL_POS, FULL_NEG);
        queue_pair(FULL_NEG, FULL_POS);
        queue_pair(24'h40_0000, 24'hC0_0000);
        queue_pair(24'd0, FULL_POS);
        settle();

        // Spare waveform code, mono, fully dry output.
        write_reg(srm_pkg::REG_WAVEFORM, {30'd0, WAVE_ALIAS});
        write_reg(srm_pkg::REG_MONO, 32'd1);
        write_reg(srm_pkg::REG_MIX, 32'd0);
        write_reg(srm_pkg::REG_PHASE_INC, 32'h0100_0000);
        @(negedge clk);
        queue_pair(FULL_POS, FULL_NEG);
        queue_pair(FULL_NEG, FULL_POS);
        queue_pair(24'h12_3456, 24'h65_4321);
        queue_pair(24'hFF_FFFF, 24'd0);
        settle();

        // Back to stereo, over-range mix, frozen carrier.
        write_reg(srm_pkg::REG_MONO, 32'd0);
        write_reg(srm_pkg::REG_MIX, 32'h0000_FFFF);
        write_reg(srm_pkg::REG_DEPTH, 32'h0000_4000);
        write_reg(srm_pkg::REG_PHASE_INC, 32'd0);
        @(negedge clk);
        queue_pair(FULL_POS, FULL_NEG);
        queue_pair(FULL_NEG, FULL_POS);
        queue_pair(FULL_POS, FULL_POS);
        queue_pair(pick_sample(), pick_sample());
        settle();

        // Random settings, each followed by a batch of random beats.
        repeat (RANDOM_PHASES)
        begin
            write_reg(srm_pkg::REG_PHASE_INC, pick_word(srm_pkg::HALF_CYCLE));
            write_reg(srm_pkg::REG_WAVEFORM, $urandom);
            write_reg(srm_pkg::REG_DEPTH, pick_word({16'd0, srm_pkg::ONE_Q15}));
            write_reg(srm_pkg::REG_SPREAD, pick_word(srm_pkg::HALF_CYCLE));
            write_reg(srm_pkg::REG_MIX, pick_word({16'd0, srm_pkg::ONE_Q15}));
            write_reg(srm_pkg::REG_MONO, ($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
            @(negedge clk);
            steady = ($urandom_range(0, 3) == 0);
            batch  = $urandom_range(30, 45);
            repeat (batch) queue_pair(pick_sample(), pick_sample());
            settle();
        end

        if (fail_count == 0 && expected_out.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
